[src/gpcc_pkg.sv]
// Shared types and constants of the GNSS position cross-check.
package gpcc_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned HEMI_W  = 8;
	localparam int unsigned TOL_W   = 20;

	localparam logic [TOL_W-1:0] TOL_RESET = 20'd100;

	// Sentence source codes.
	localparam logic [1:0] SRC_GGA     = 2'd0;
	localparam logic [1:0] SRC_GLL     = 2'd1;
	localparam logic [1:0] SRC_RMC     = 2'd2;
	localparam logic [1:0] SRC_INVALID = 2'd3;

	// Pair codes reported with each result.
	localparam logic [1:0] PAIR_GGA_GLL = 2'd0;
	localparam logic [1:0] PAIR_GGA_RMC = 2'd1;
	localparam logic [1:0] PAIR_GLL_RMC = 2'd2;
	localparam logic [1:0] PAIR_NONE    = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] lat;
		logic signed [COORD_W-1:0] lon;
		logic [HEMI_W-1:0]         lat_h;
		logic [HEMI_W-1:0]         lon_h;
	} report_t;

endpackage

[src/gpcc_in_if.sv]
// Input channel carrying one tagged position report per beat.
interface gpcc_in_if;
	logic                                    valid;
	logic                                    ready;
	logic [1:0]                              func;
	logic signed [gpcc_pkg::COORD_W-1:0]     latitude;
	logic signed [gpcc_pkg::COORD_W-1:0]     longitude;
	logic [gpcc_pkg::HEMI_W-1:0]             lat_hemisphere;
	logic [gpcc_pkg::HEMI_W-1:0]             lon_hemisphere;

	modport source (output valid, func, latitude, longitude, lat_hemisphere, lon_hemisphere,
		input ready);
	modport sink (input valid, func, latitude, longitude, lat_hemisphere, lon_hemisphere,
		output ready);
endinterface

[src/gpcc_out_if.sv]
// Result channel carrying the held fix and check status per beat.
interface gpcc_out_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    fix_updated;
	logic [1:0]                              pair_used;
	logic signed [gpcc_pkg::COORD_W-1:0]     fix_latitude;
	logic signed [gpcc_pkg::COORD_W-1:0]     fix_longitude;
	logic [gpcc_pkg::HEMI_W-1:0]             fix_lat_hemisphere;
	logic [gpcc_pkg::HEMI_W-1:0]             fix_lon_hemisphere;
	logic                                    bad_source;

	modport source (output valid, fix_updated, pair_used, fix_latitude, fix_longitude,
		fix_lat_hemisphere, fix_lon_hemisphere, bad_source, input ready);
	modport sink (input valid, fix_updated, pair_used, fix_latitude, fix_longitude,
		fix_lat_hemisphere, fix_lon_hemisphere, bad_source, output ready);
endinterface

[src/gpcc_pair_match.sv]
// Agreement test between two stored position reports.
module gpcc_pair_match (
	input  gpcc_pkg::report_t                 a,
	input  gpcc_pkg::report_t                 b,
	input  logic [gpcc_pkg::TOL_W-1:0]        tol,
	output logic                              agree
);

	localparam int unsigned DW = gpcc_pkg::COORD_W + 1;

	logic signed [DW-1:0] lat_d;
	logic signed [DW-1:0] lon_d;
	logic [DW-1:0]        lat_abs;
	logic [DW-1:0]        lon_abs;
	logic [DW-1:0]        tol_x;
	logic                 all_zero;

	// Differences are exact at one extra bit; the magnitude of the most
	// negative difference still fits as an unsigned value of the same width.
	assign lat_d = DW'(a.lat) - DW'(b.lat);
	assign lon_d = DW'(a.lon) - DW'(b.lon);
	assign lat_abs = lat_d[DW-1] ? DW'(-lat_d) : DW'(lat_d);
	assign lon_abs = lon_d[DW-1] ? DW'(-lon_d) : DW'(lon_d);
	assign tol_x = DW'(tol);

	assign all_zero = (a.lat == '0) && (a.lon == '0) && (b.lat == '0) && (b.lon == '0);

	assign agree = !all_zero && (lat_abs < tol_x) && (lon_abs < tol_x) &&
		(a.lat_h == b.lat_h) && (a.lon_h == b.lon_h);

endmodule

[src/gnss_position_cross_check.sv]
// Top level of the GNSS position cross-check.
//
//  channel  direction  beat contents
//  rpt      in         func, latitude, longitude, lat/lon hemisphere bytes
//  res      out        fix_updated, pair_used, held fix, bad_source
//  cfg      in         cfg_we, cfg_wdata (match tolerance, 20 bits)
//
// Each report is registered at the input, then checked combinationally against the
// stored reports and written to the result register, so a beat can be taken every
// cycle while results are taken. A result is offered once its report has passed the
// input register and the check into the result register.
// While a result waits, the input register takes at most one more beat and then
// holds off the input until the result is taken.
// Reset clears the stored reports, the held fix and sets the tolerance to 100.
module gnss_position_cross_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gpcc_pkg::TOL_W-1:0]       cfg_wdata,
	gpcc_in_if.sink                          rpt,
	gpcc_out_if.source                       res
);

	logic [gpcc_pkg::TOL_W-1:0] tol_q;

	logic                       v_s1;
	logic [1:0]                 func_s1;
	gpcc_pkg::report_t          item_s1;

	gpcc_pkg::report_t          gga_q;
	gpcc_pkg::report_t          gll_q;
	gpcc_pkg::report_t          fix_q;

	logic                       res_valid_q;
	logic                       res_updated_q;
	logic [1:0]                 res_pair_q;
	logic                       res_bad_q;

	logic                       adv;
	logic                       ag_gga_gll;
	logic                       ag_gga_rmc;
	logic                       ag_gll_rmc;
	logic [1:0]                 pair_c;
	gpcc_pkg::report_t          fix_c;

	assign adv       = v_s1 && (!res_valid_q || res.ready);
	assign rpt.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= gpcc_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rpt.ready) begin
			v_s1 <= rpt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt.valid && rpt.ready) begin
			func_s1       <= rpt.func;
			item_s1.lat   <= rpt.latitude;
			item_s1.lon   <= rpt.longitude;
			item_s1.lat_h <= rpt.lat_hemisphere;
			item_s1.lon_h <= rpt.lon_hemisphere;
		end
	end

	// The RMC member of a check is the report being processed.
	gpcc_pair_match u_gga_gll (.a(gga_q), .b(gll_q),   .tol(tol_q), .agree(ag_gga_gll));
	gpcc_pair_match u_gga_rmc (.a(gga_q), .b(item_s1), .tol(tol_q), .agree(ag_gga_rmc));
	gpcc_pair_match u_gll_rmc (.a(gll_q), .b(item_s1), .tol(tol_q), .agree(ag_gll_rmc));

	always_comb begin
		pair_c = gpcc_pkg::PAIR_NONE;
		fix_c  = fix_q;
		if (func_s1 == gpcc_pkg::SRC_RMC) begin
			if (ag_gga_gll) begin
				pair_c = gpcc_pkg::PAIR_GGA_GLL;
				fix_c  = gga_q;
			end else if (ag_gga_rmc) begin
				pair_c = gpcc_pkg::PAIR_GGA_RMC;
				fix_c  = gga_q;
			end else if (ag_gll_rmc) begin
				pair_c = gpcc_pkg::PAIR_GLL_RMC;
				fix_c  = gll_q;
			end
		end
	end

	// Stored reports and held fix change only when a beat moves to the result.
	// An RMC report is only ever checked as the report in flight, so it is not kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gga_q <= '0;
			gll_q <= '0;
			fix_q <= '0;
		end else if (adv) begin
			case (func_s1)
				gpcc_pkg::SRC_GGA: gga_q <= item_s1;
				gpcc_pkg::SRC_GLL: gll_q <= item_s1;
				default: ;
			endcase
			fix_q <= fix_c;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_pair_q    <= pair_c;
			res_updated_q <= (pair_c != gpcc_pkg::PAIR_NONE);
			res_bad_q     <= (func_s1 == gpcc_pkg::SRC_INVALID);
		end
	end

	assign res.valid              = res_valid_q;
	assign res.fix_updated        = res_updated_q;
	assign res.pair_used          = res_pair_q;
	assign res.fix_latitude       = fix_q.lat;
	assign res.fix_longitude      = fix_q.lon;
	assign res.fix_lat_hemisphere = fix_q.lat_h;
	assign res.fix_lon_hemisphere = fix_q.lon_h;
	assign res.bad_source         = res_bad_q;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the GNSS position cross-check block.
module testbench;
	import gpcc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int BLOCKS = 7;
	localparam int BLOCK_ITEMS = 100;
	localparam logic [HEMI_W-1:0] HEMI_N = "N";
	localparam logic [HEMI_W-1:0] HEMI_S = "S";
	localparam logic [HEMI_W-1:0] HEMI_E = "E";
	localparam logic [HEMI_W-1:0] HEMI_W_CHAR = "W";

	typedef struct packed {
		logic       updated;
		logic [1:0] pair;
		report_t    fix;
		logic       bad;
	} fix_result_t;

	// Tracks stored reports, the held fix and the tolerance, and keeps the
	// results still owed by the block in arrival order.
	class fix_scoreboard;
		report_t          src_rpt[3];
		report_t          held;
		logic [TOL_W-1:0] tolerance;
		fix_result_t      expected_q[$];
		int               errors;
		int               noted;
		int               checked;
		int               bad_count;
		int               pair_hits[4];

		function new();
			foreach (src_rpt[i]) src_rpt[i] = '0;
			held = '0;
			tolerance = TOL_RESET;
			errors = 0;
			noted = 0;
			checked = 0;
			bad_count = 0;
			foreach (pair_hits[i]) pair_hits[i] = 0;
		endfunction

		function void set_tolerance(logic [TOL_W-1:0] value);
			tolerance = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Differences are taken at 64 bits, so extreme coordinates cannot wrap.
		function bit close_enough(logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
			longint d;
			d = longint'(a) - longint'(b);
			if (d < 0) d = -d;
			return d < longint'(tolerance);
		endfunction

		function bit reports_agree(report_t p, report_t q);
			if (p.lat == 0 && p.lon == 0 && q.lat == 0 && q.lon == 0) return 1'b0;
			return close_enough(p.lat, q.lat) && close_enough(p.lon, q.lon) &&
				p.lat_h == q.lat_h && p.lon_h == q.lon_h;
		endfunction

		function void note_report(logic [1:0] func, report_t r);
			fix_result_t e;
			e.updated = 1'b0;
			e.pair = PAIR_NONE;
			e.bad = 1'b0;
			if (func == SRC_INVALID) begin
				e.bad = 1'b1;
				bad_count++;
			end else begin
				src_rpt[func] = r;
				if (func == SRC_RMC) begin
					if (reports_agree(src_rpt[SRC_GGA], src_rpt[SRC_GLL])) begin
						held = src_rpt[SRC_GGA];
						e.pair = PAIR_GGA_GLL;
					end else if (reports_agree(src_rpt[SRC_GGA], src_rpt[SRC_RMC])) begin
						held = src_rpt[SRC_GGA];
						e.pair = PAIR_GGA_RMC;
					end else if (reports_agree(src_rpt[SRC_GLL], src_rpt[SRC_RMC])) begin
						held = src_rpt[SRC_GLL];
						e.pair = PAIR_GLL_RMC;
					end
					if (e.pair != PAIR_NONE) begin
						e.updated = 1'b1;
						pair_hits[e.pair]++;
					end
				end
			end
			e.fix = held;
			expected_q.push_back(e);
			noted++;
		endfunction

		function void check_result(fix_result_t got);
			fix_result_t e;
			if (expected_q.size() == 0) begin
				$error("result beat arrived with no report pending");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (got.updated !== e.updated) begin
				$error("fix_updated: expected %0d, got %0d", e.updated, got.updated);
				errors++;
			end
			if (got.pair !== e.pair) begin
				$error("pair_used: expected %0d, got %0d", e.pair, got.pair);
				errors++;
			end
			if (got.fix.lat !== e.fix.lat) begin
				$error("fix_latitude: expected %0d, got %0d", e.fix.lat, got.fix.lat);
				errors++;
			end
			if (got.fix.lon !== e.fix.lon) begin
				$error("fix_longitude: expected %0d, got %0d", e.fix.lon, got.fix.lon);
				errors++;
			end
			if (got.fix.lat_h !== e.fix.lat_h) begin
				$error("fix_lat_hemisphere: expected %0d, got %0d", e.fix.lat_h, got.fix.lat_h);
				errors++;
			end
			if (got.fix.lon_h !== e.fix.lon_h) begin
				$error("fix_lon_hemisphere: expected %0d, got %0d", e.fix.lon_h, got.fix.lon_h);
				errors++;
			end
			if (got.bad !== e.bad) begin
				$error("bad_source: expected %0d, got %0d", e.bad, got.bad);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [TOL_W-1:0] cfg_wdata;
	int               send_idle;
	int               recv_idle;
	int               tol_writes;
	fix_scoreboard    sb;

	gpcc_in_if  rpt_ch();
	gpcc_out_if res_ch();

	gnss_position_cross_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rpt       (rpt_ch),
		.res       (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic report_t pos_report(input logic signed [COORD_W-1:0] lat,
		input logic signed [COORD_W-1:0] lon, input logic [HEMI_W-1:0] lat_h,
		input logic [HEMI_W-1:0] lon_h);
		report_t r;
		r.lat = lat;
		r.lon = lon;
		r.lat_h = lat_h;
		r.lon_h = lon_h;
		return r;
	endfunction

	// Returns right after the edge at which the beat was taken, with valid
	// still high, so the next call can keep it high without a glitch.
	task automatic send_report(input logic [1:0] func, input report_t r);
		while ($urandom_range(99) < send_idle) begin
			rpt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rpt_ch.valid <= 1'b1;
		rpt_ch.func <= func;
		rpt_ch.latitude <= r.lat;
		rpt_ch.longitude <= r.lon;
		rpt_ch.lat_hemisphere <= r.lat_h;
		rpt_ch.lon_hemisphere <= r.lon_h;
		do @(posedge clk); while (rpt_ch.ready !== 1'b1);
		sb.note_report(func, r);
	endtask

	task automatic drain_results();
		rpt_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_tolerance(value);
		tol_writes++;
	endtask

	// One round of reports from the three sources around a common position,
	// with jitter just past the tolerance and the odd corrupted hemisphere.
	// Noise beats with any source code are mixed in now and then.
	task automatic send_round(input logic [TOL_W-1:0] tol);
		logic signed [COORD_W-1:0] base_lat;
		logic signed [COORD_W-1:0] base_lon;
		logic [HEMI_W-1:0]         lat_c;
		logic [HEMI_W-1:0]         lon_c;
		logic [1:0]                order[3];
		int                        jitter;
		report_t                   r;
		jitter = (tol == 0) ? 3 : int'(tol) + int'(tol) / 4 + 1;
		if ($urandom_range(11) == 0) begin
			base_lat = '0;
			base_lon = '0;
			jitter = 0;
		end else begin
			base_lat = $urandom;
			base_lon = $urandom;
		end
		lat_c = $urandom_range(1) ? HEMI_N : HEMI_S;
		lon_c = $urandom_range(1) ? HEMI_E : HEMI_W_CHAR;
		if ($urandom_range(99) < 70) begin
			order[0] = $urandom_range(1) ? SRC_GGA : SRC_GLL;
			order[1] = (order[0] == SRC_GGA) ? SRC_GLL : SRC_GGA;
			order[2] = SRC_RMC;
		end else begin
			foreach (order[i]) order[i] = 2'($urandom_range(2));
		end
		foreach (order[i]) begin
			if ($urandom_range(99) < 12)
				send_report(2'($urandom_range(3)), pos_report($urandom, $urandom,
					HEMI_W'($urandom), HEMI_W'($urandom)));
			r.lat = base_lat + ($urandom_range(2 * jitter) - jitter);
			r.lon = base_lon + ($urandom_range(2 * jitter) - jitter);
			r.lat_h = ($urandom_range(9) == 0) ? HEMI_W'($urandom) : lat_c;
			r.lon_h = ($urandom_range(9) == 0) ? HEMI_W'($urandom) : lon_c;
			send_report(order[i], r);
		end
	endtask

	always @(posedge clk) begin : result_sink
		fix_result_t got;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.updated = res_ch.fix_updated;
			got.pair = res_ch.pair_used;
			got.fix.lat = res_ch.fix_latitude;
			got.fix.lon = res_ch.fix_longitude;
			got.fix.lat_h = res_ch.fix_lat_hemisphere;
			got.fix.lon_h = res_ch.fix_lon_hemisphere;
			got.bad = res_ch.bad_source;
			sb.check_result(got);
		end
		res_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("gnss_position_cross_check: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [TOL_W-1:0] block_tol;
		int               target;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rpt_ch.valid = 1'b0;
		rpt_ch.func = SRC_GGA;
		rpt_ch.latitude = '0;
		rpt_ch.longitude = '0;
		rpt_ch.lat_hemisphere = '0;
		rpt_ch.lon_hemisphere = '0;
		res_ch.ready = 1'b0;
		send_idle = 31;
		recv_idle = 55;
		tol_writes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats at the reset tolerance of 100.
		send_report(SRC_RMC, pos_report(0, 0, 8'h00, 8'h00));
		send_report(SRC_INVALID, pos_report(32'h7FFFFFFF, 32'h80000000, 8'hFF, 8'h00));
		send_report(SRC_INVALID, pos_report(32'h80000000, 32'h7FFFFFFF, 8'h00, 8'hFF));
		// GGA and GLL agree just inside the tolerance.
		send_report(SRC_GGA, pos_report(1000, 2000, HEMI_N, HEMI_E));
		send_report(SRC_GLL, pos_report(1099, 1901, HEMI_N, HEMI_E));
		send_report(SRC_RMC, pos_report(-5000, -5000, HEMI_S, HEMI_W_CHAR));
		// A difference equal to the tolerance does not agree; GGA/RMC does.
		send_report(SRC_GLL, pos_report(1100, 2000, HEMI_N, HEMI_E));
		send_report(SRC_RMC, pos_report(1050, 2050, HEMI_N, HEMI_E));
		// Extreme coordinates; only GLL/RMC agrees.
		send_report(SRC_GGA, pos_report(32'h80000000, 32'h80000000, HEMI_S, HEMI_W_CHAR));
		send_report(SRC_GLL, pos_report(32'h7FFFFFFF, 32'h7FFFFFFF, HEMI_N, HEMI_E));
		send_report(SRC_RMC, pos_report(2147483600, 2147483647, HEMI_N, HEMI_E));
		// Same coordinates but hemisphere bytes differ in every pair: fix is kept.
		send_report(SRC_GGA, pos_report(500, 500, HEMI_N, HEMI_E));
		send_report(SRC_GLL, pos_report(500, 500, HEMI_N, HEMI_W_CHAR));
		send_report(SRC_RMC, pos_report(500, 500, HEMI_S, HEMI_E));
		// All-zero pairs never agree, even with equal hemispheres.
		send_report(SRC_GGA, pos_report(0, 0, HEMI_N, HEMI_E));
		send_report(SRC_GLL, pos_report(0, 0, HEMI_N, HEMI_E));
		send_report(SRC_RMC, pos_report(0, 0, HEMI_N, HEMI_E));
		// One nonzero coordinate in the pair is enough to allow agreement.
		send_report(SRC_GGA, pos_report(0, 99, HEMI_N, HEMI_E));
		send_report(SRC_RMC, pos_report(0, 0, HEMI_N, HEMI_E));
		// Negative coordinates and odd hemisphere bytes.
		send_report(SRC_GGA, pos_report(-1, -1, 8'hFF, 8'hFF));
		send_report(SRC_GLL, pos_report(-100, -1, 8'hFF, 8'hFF));
		send_report(SRC_RMC, pos_report(5, 5, 8'h00, 8'h00));

		for (int blk = 0; blk < BLOCKS; blk++) begin
			if (blk < 2) begin
				send_idle = 31;
				recv_idle = 55;
			end else if (blk < 4) begin
				send_idle = 55;
				recv_idle = 31;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (blk)
				0: block_tol = 20'd1000000;
				1: block_tol = '0;
				3: block_tol = 20'd1;
				5: block_tol = TOL_RESET;
				default: block_tol = TOL_W'($urandom_range(1000000));
			endcase
			// The tolerance changes only once every owed result is back.
			drain_results();
			write_tolerance(block_tol);
			target = sb.noted + BLOCK_ITEMS;
			while (sb.noted < target) send_round(block_tol);
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end
		$display("Checked %0d results from %0d reports across %0d tolerance settings, %0d bad sources.",
			sb.checked, sb.noted, tol_writes + 1, sb.bad_count);
		$display("Held fix replaced via GGA/GLL %0d, GGA/RMC %0d, GLL/RMC %0d times.",
			sb.pair_hits[PAIR_GGA_GLL], sb.pair_hits[PAIR_GGA_RMC], sb.pair_hits[PAIR_GLL_RMC]);
		if (sb.errors == 0)
			$display("gnss_position_cross_check: match");
		else
			$display("gnss_position_cross_check: mismatch");
		$finish;
	end

endmodule
